@@ hw/rtl/tlnef_pkg.sv @@
package tlnef_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 8;
  localparam int BodyBytes     = 4;

  localparam logic [CfgIndexWidth-1:0] CFG_NUMBER_MODE      = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_SHOW_ENDS        = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_SHOW_TABS        = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_SHOW_NONPRINTING = 3'd4;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_ALL  = 2'd1;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;

  localparam logic [6:0] LOW_DEL   = 7'd127;
  localparam logic [7:0] CARET_OFS = 8'd64;

  typedef struct packed {
    logic                     has_num;
    logic [2:0]               body_len;
    logic [8*BodyBytes-1:0]   body;
  } job_t;

  typedef enum logic [1:0] {
    PH_NUM,
    PH_TAB,
    PH_BODY
  } phase_t;

endpackage

@@ hw/rtl/tlnef_queue.sv @@
module tlnef_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data,
  input  logic             rd_en
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  logic do_wr;
  logic do_rd;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("Queue holds more entries than its depth.");

  a_pointer_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) || (count == CW'(DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("Queue pointers disagree with the fill count.");

endmodule

@@ hw/rtl/tlnef_front.sv @@
module tlnef_front #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_byte,
  input  logic                                file_start,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tlnef_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [tlnef_pkg::CfgDataWidth-1:0]  cfg_data,
  input  logic                                q_full,
  output logic                                push,
  output tlnef_pkg::job_t                     job,
  output logic [4*NUMBER_DIGITS-1:0]          job_num
);
  import tlnef_pkg::*;

  localparam int NW = 4 * NUMBER_DIGITS;

  logic [1:0]    number_mode;
  logic          show_ends;
  logic          squeeze_blank;
  logic          show_tabs;
  logic          show_nonprinting;

  logic [NW-1:0] line_num;
  logic          at_line_start;
  logic          prev_blank;

  logic [NW-1:0] line_num_next;
  logic          at_line_start_next;
  logic          prev_blank_next;

  logic          accept;
  logic          drop;
  logic          eff_start;
  logic          eff_prev;
  logic [NW-1:0] eff_num;
  logic [NW-1:0] inc_num;
  logic [4:0]    dsum;
  logic          carry;
  logic [6:0]    lo;
  logic [15:0]   caret;
  logic [2:0]    caret_len;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign push      = accept && !drop;
  assign job_num   = eff_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_mode      <= MODE_NONE;
      show_ends        <= 1'b0;
      squeeze_blank    <= 1'b0;
      show_tabs        <= 1'b0;
      show_nonprinting <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUMBER_MODE:      number_mode      <= cfg_data[1:0];
        CFG_SHOW_ENDS:        show_ends        <= cfg_data[0];
        CFG_SQUEEZE_BLANK:    squeeze_blank    <= cfg_data[0];
        CFG_SHOW_TABS:        show_tabs        <= cfg_data[0];
        CFG_SHOW_NONPRINTING: show_nonprinting <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    carry = 1'b1;
    dsum  = '0;
    for (int d = 0; d < NUMBER_DIGITS; d++) begin
      dsum = {1'b0, eff_num[4*d +: 4]} + {4'd0, carry};
      if (dsum > 5'd9) begin
        inc_num[4*d +: 4] = 4'd0;
        carry             = 1'b1;
      end else begin
        inc_num[4*d +: 4] = dsum[3:0];
        carry             = 1'b0;
      end
    end
  end

  always_comb begin
    lo = in_byte[6:0];
    if (lo[6:5] == 2'b00) begin
      caret     = {{1'b0, lo} + CARET_OFS, CH_CARET};
      caret_len = 3'd2;
    end else if (lo == LOW_DEL) begin
      caret     = {CH_QMARK, CH_CARET};
      caret_len = 3'd2;
    end else begin
      caret     = {8'h00, 1'b0, lo};
      caret_len = 3'd1;
    end
  end

  always_comb begin
    eff_start          = file_start || at_line_start;
    eff_prev           = !file_start && prev_blank;
    eff_num            = file_start ? NW'(1) : line_num;
    drop               = 1'b0;
    job.has_num        = 1'b0;
    job.body_len       = 3'd1;
    job.body           = {24'h0, in_byte};
    at_line_start_next = eff_start;
    prev_blank_next    = eff_prev;
    if (in_byte == CH_LF) begin
      if (eff_start) begin
        if (squeeze_blank && eff_prev) begin
          drop = 1'b1;
        end else begin
          job.has_num     = (number_mode == MODE_ALL);
          prev_blank_next = 1'b1;
        end
      end else begin
        prev_blank_next = 1'b0;
      end
      at_line_start_next = 1'b1;
      if (show_ends) begin
        job.body     = {16'h0, CH_LF, CH_DOLLAR};
        job.body_len = 3'd2;
      end
    end else begin
      job.has_num        = eff_start && (number_mode != MODE_NONE);
      at_line_start_next = 1'b0;
      if (in_byte == CH_TAB) begin
        if (show_tabs) begin
          job.body     = {16'h0, CH_I, CH_CARET};
          job.body_len = 3'd2;
        end
      end else if (show_nonprinting) begin
        if (in_byte[7]) begin
          job.body     = {caret, CH_DASH, CH_M};
          job.body_len = caret_len + 3'd2;
        end else begin
          job.body     = {16'h0, caret};
          job.body_len = caret_len;
        end
      end
    end
    line_num_next = job.has_num ? inc_num : eff_num;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_num      <= NW'(1);
      at_line_start <= 1'b1;
      prev_blank    <= 1'b0;
    end else if (accept) begin
      line_num      <= line_num_next;
      at_line_start <= at_line_start_next;
      prev_blank    <= prev_blank_next;
    end
  end

  a_number_enabled: assert property (@(posedge clk) disable iff (rst)
    push && job.has_num |-> (number_mode != MODE_NONE))
    else $error("Line number scheduled while numbering is off.");

endmodule

@@ hw/rtl/tlnef_back.sv @@
module tlnef_back #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  tlnef_pkg::job_t            q_job,
  input  logic [4*NUMBER_DIGITS-1:0] q_num,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       last
);
  import tlnef_pkg::*;

  localparam int NW = 4 * NUMBER_DIGITS;
  localparam int DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

  logic                   cur_valid;
  phase_t                 phase;
  logic [NW-1:0]          num_sh;
  logic                   seen;
  logic [DW-1:0]          dcnt;
  logic [8*BodyBytes-1:0] body_sh;
  logic [2:0]             blen;

  logic                   cur_valid_next;
  phase_t                 phase_next;
  logic [NW-1:0]          num_sh_next;
  logic                   seen_next;
  logic [DW-1:0]          dcnt_next;
  logic [8*BodyBytes-1:0] body_sh_next;
  logic [2:0]             blen_next;
  logic                   out_valid_next;
  logic [7:0]             out_byte_next;
  logic                   last_next;

  logic                   out_free;
  logic [7:0]             ch;
  logic                   final_byte;
  logic [3:0]             top;
  logic [3:0]             digit;
  logic                   seen_now;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    top      = num_sh[NW-1 -: 4];
    digit    = (top > 4'd9) ? 4'd9 : top;
    seen_now = seen || (top != 4'd0) || (dcnt == DW'(NUMBER_DIGITS - 1));
  end

  always_comb begin
    cur_valid_next = cur_valid;
    phase_next     = phase;
    num_sh_next    = num_sh;
    seen_next      = seen;
    dcnt_next      = dcnt;
    body_sh_next   = body_sh;
    blen_next      = blen;
    out_valid_next = out_free ? 1'b0 : out_valid;
    out_byte_next  = out_byte;
    last_next      = last;
    ch             = body_sh[7:0];
    final_byte     = 1'b0;

    unique case (phase)
      PH_NUM: begin
        ch = seen_now ? (CH_ZERO + {4'd0, digit}) : CH_SPACE;
      end
      PH_TAB: begin
        ch = CH_TAB;
      end
      PH_BODY: begin
        ch         = body_sh[7:0];
        final_byte = (blen == 3'd1);
      end
      default: ;
    endcase

    if (cur_valid && out_free) begin
      out_valid_next = 1'b1;
      out_byte_next  = ch;
      last_next      = final_byte;
      unique case (phase)
        PH_NUM: begin
          seen_next   = seen_now;
          num_sh_next = num_sh << 4;
          if (dcnt == DW'(NUMBER_DIGITS - 1)) begin
            phase_next = PH_TAB;
          end else begin
            dcnt_next = dcnt + 1'b1;
          end
        end
        PH_TAB: begin
          phase_next = PH_BODY;
        end
        PH_BODY: begin
          body_sh_next = body_sh >> 8;
          blen_next    = blen - 3'd1;
          if (final_byte) begin
            cur_valid_next = 1'b0;
          end
        end
        default: ;
      endcase
    end

    pop = q_valid && (!cur_valid || (out_free && final_byte));
    if (pop) begin
      cur_valid_next = 1'b1;
      phase_next     = q_job.has_num ? PH_NUM : PH_BODY;
      num_sh_next    = q_num;
      seen_next      = 1'b0;
      dcnt_next      = '0;
      body_sh_next   = q_job.body;
      blen_next      = q_job.body_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= PH_BODY;
      out_valid <= 1'b0;
    end else begin
      cur_valid <= cur_valid_next;
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    num_sh   <= num_sh_next;
    seen     <= seen_next;
    dcnt     <= dcnt_next;
    body_sh  <= body_sh_next;
    blen     <= blen_next;
    out_byte <= out_byte_next;
    last     <= last_next;
  end

  a_body_left: assert property (@(posedge clk) disable iff (rst)
    cur_valid && (phase == PH_BODY) |-> (blen != 3'd0))
    else $error("Job in its body phase has no bytes left.");

  a_pop_on_done: assert property (@(posedge clk) disable iff (rst)
    pop && cur_valid |=> out_valid && last)
    else $error("Next job loaded before the current one finished.");

endmodule

@@ hw/rtl/text_line_number_escape_filter.sv @@
// Text filter in the manner of cat: one input byte per transfer, zero to
// NUMBER_DIGITS + 5 output bytes per input byte, the last one flagged by
// last. The front half takes one byte per cycle, updates the line state and
// queues a job; the back half sends one output byte per cycle unless out_stall
// holds it, and input is taken every cycle while the QUEUE_DEPTH-entry job
// queue has room. The first output byte of a byte passes through the job
// queue, the back half's job registers and its output register.
// Registers 0 to 4 are number_mode, show_ends, squeeze_blank, show_tabs and
// show_nonprinting; write them only while the block is idle.
module text_line_number_escape_filter #(
  parameter int NUMBER_DIGITS = 6,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_byte,
  input  logic                                file_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_byte,
  output logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tlnef_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [tlnef_pkg::CfgDataWidth-1:0]  cfg_data
);
  import tlnef_pkg::*;

  localparam int NW = 4 * NUMBER_DIGITS;
  localparam int QW = NW + $bits(job_t);

  logic          push;
  job_t          f_job;
  logic [NW-1:0] f_num;
  logic          q_full;
  logic          q_valid;
  logic [QW-1:0] q_data;
  logic          pop;
  job_t          b_job;
  logic [NW-1:0] b_num;

  assign b_job = q_data[$bits(job_t)-1:0];
  assign b_num = q_data[QW-1 -: NW];

  tlnef_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .file_start (file_start),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .job        (f_job),
    .job_num    (f_num)
  );

  tlnef_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  ({f_num, f_job}),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_data),
    .rd_en    (pop)
  );

  tlnef_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (b_job),
    .q_num     (b_num),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tlnef_pkg::*;

  localparam int NumDigits     = 6;
  localparam int WatchdogLimit = 3000;
  localparam int HoldCycles    = 300;
  localparam int SettleCycles  = 20;
  localparam int DrainCycles   = 30;
  localparam int PhaseItems    = 50;

  localparam logic [1:0] MODE_NONBLANK = 2'd2;
  localparam logic [1:0] MODE_THREE    = 2'd3;
  localparam logic [CfgIndexWidth-1:0] CfgFirstUnused = CFG_SHOW_NONPRINTING + 1'b1;

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic [7:0]               in_byte    = '0;
  logic                     file_start = 1'b0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic [7:0]               out_byte;
  logic                     last;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index  = '0;
  logic [CfgDataWidth-1:0]  cfg_data   = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holds_asked    = 0;
  int holds_taken    = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;

  text_line_number_escape_filter #(
    .NUMBER_DIGITS(NumDigits)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .file_start(file_start),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  class cat_output_scoreboard;
    logic [1:0]             number_mode;
    logic                   show_ends;
    logic                   squeeze_blank;
    logic                   show_tabs;
    logic                   show_nonprinting;
    logic [4*NumDigits-1:0] line_bcd;
    logic                   at_line_start;
    logic                   prev_line_blank;
    logic [7:0]             step_bytes[$];
    logic [8:0]             expected_out_q[$];
    int                     errors;

    function new();
      number_mode      = MODE_NONE;
      show_ends        = 1'b0;
      squeeze_blank    = 1'b0;
      show_tabs        = 1'b0;
      show_nonprinting = 1'b0;
      line_bcd         = (4*NumDigits)'(1);
      at_line_start    = 1'b1;
      prev_line_blank  = 1'b0;
      errors           = 0;
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] index, logic [7:0] data);
      case (index)
        CFG_NUMBER_MODE:      number_mode      = data[1:0];
        CFG_SHOW_ENDS:        show_ends        = data[0];
        CFG_SQUEEZE_BLANK:    squeeze_blank    = data[0];
        CFG_SHOW_TABS:        show_tabs        = data[0];
        CFG_SHOW_NONPRINTING: show_nonprinting = data[0];
        default: ;
      endcase
    endfunction

    // Prints the current line number right-aligned, then advances it in BCD.
    function void put_line_number();
      logic [3:0] digit;
      logic       seen;
      logic       carry;
      seen = 1'b0;
      for (int d = NumDigits - 1; d >= 0; d--) begin
        digit = line_bcd[4*d +: 4];
        if (digit != 4'd0 || d == 0) seen = 1'b1;
        step_bytes.push_back(seen ? CH_ZERO + 8'(digit) : CH_SPACE);
      end
      step_bytes.push_back(CH_TAB);
      carry = 1'b1;
      for (int d = 0; d < NumDigits; d++) begin
        digit = line_bcd[4*d +: 4];
        if (carry) begin
          if (digit >= 4'd9) begin
            digit = 4'd0;
          end else begin
            digit = digit + 4'd1;
            carry = 1'b0;
          end
        end
        line_bcd[4*d +: 4] = digit;
      end
    endfunction

    function void put_caret(logic [6:0] c);
      if (c < CH_SPACE[6:0]) begin
        step_bytes.push_back(CH_CARET);
        step_bytes.push_back({1'b0, c} + CARET_OFS);
      end else if (c == LOW_DEL) begin
        step_bytes.push_back(CH_CARET);
        step_bytes.push_back(CH_QMARK);
      end else begin
        step_bytes.push_back({1'b0, c});
      end
    endfunction

    function void take_text_byte(logic [7:0] c, logic fs);
      step_bytes.delete();
      if (fs) begin
        line_bcd        = (4*NumDigits)'(1);
        at_line_start   = 1'b1;
        prev_line_blank = 1'b0;
      end
      if (c == CH_LF) begin
        if (at_line_start) begin
          if (squeeze_blank && prev_line_blank) return;
          if (number_mode == MODE_ALL) put_line_number();
          prev_line_blank = 1'b1;
        end else begin
          prev_line_blank = 1'b0;
        end
        if (show_ends) step_bytes.push_back(CH_DOLLAR);
        step_bytes.push_back(CH_LF);
        at_line_start = 1'b1;
      end else begin
        if (at_line_start && number_mode != MODE_NONE) put_line_number();
        at_line_start = 1'b0;
        if (c == CH_TAB) begin
          if (show_tabs) begin
            step_bytes.push_back(CH_CARET);
            step_bytes.push_back(CH_I);
          end else begin
            step_bytes.push_back(CH_TAB);
          end
        end else if (show_nonprinting) begin
          if (c[7]) begin
            step_bytes.push_back(CH_M);
            step_bytes.push_back(CH_DASH);
          end
          put_caret(c[6:0]);
        end else begin
          step_bytes.push_back(c);
        end
      end
      foreach (step_bytes[i]) begin
        expected_out_q.push_back({i == step_bytes.size() - 1, step_bytes[i]});
      end
    endfunction

    task report(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_out_byte(logic [7:0] b, logic is_last);
      logic [8:0] want;
      if (expected_out_q.size() == 0) begin
        report($sformatf("unexpected out_byte %02h last %0b", b, is_last));
        return;
      end
      want = expected_out_q.pop_front();
      if (b !== want[7:0]) begin
        report($sformatf("out_byte %02h, expected %02h", b, want[7:0]));
      end
      if (is_last !== want[8]) begin
        report($sformatf("last %0b on out_byte %02h, expected %0b", is_last, b, want[8]));
      end
    endtask

    function int pending();
      return expected_out_q.size();
    endfunction
  endclass

  cat_output_scoreboard sb = new();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls at random, or holds off for a long stretch on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_taken != holds_asked) begin
      out_stall   <= 1'b1;
      hold_left   <= HoldCycles;
      holds_taken <= holds_taken + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_out_byte(out_byte, last);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Timeout: no transfer for %0d cycles", WatchdogLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [7:0] random_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 15) return CH_LF;
    if (r < 25) return CH_TAB;
    if (r < 75) return 8'($urandom_range(126, CH_SPACE));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_byte(logic [7:0] b, logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    file_start <= fs;
    do @(posedge clk); while (in_stall);
    sb.take_text_byte(b, fs);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CfgIndexWidth-1:0] index, logic [7:0] val, int width);
    logic [7:0] mask;
    logic [7:0] data;
    mask = 8'((1 << width) - 1);
    data = (8'($urandom) & ~mask) | (val & mask);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, data);
    @(negedge clk);
  endtask

  // Setting word: {number_mode, show_ends, squeeze_blank, show_tabs, show_nonprinting}.
  task automatic configure(logic [5:0] s);
    cfg_write(CfgFirstUnused + CfgIndexWidth'($urandom_range(2)), 8'($urandom), 8);
    cfg_write(CFG_NUMBER_MODE, 8'(s[5:4]), 2);
    cfg_write(CFG_SHOW_ENDS, 8'(s[3]), 1);
    cfg_write(CFG_SQUEEZE_BLANK, 8'(s[2]), 1);
    cfg_write(CFG_SHOW_TABS, 8'(s[1]), 1);
    cfg_write(CFG_SHOW_NONPRINTING, 8'(s[0]), 1);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // A squeezed newline has no output, so the block may still be busy once
  // the queue is empty; a further SettleCycles wait covers its pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    wait_drained();
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic directed_text();
    logic [7:0] text_a [18];
    logic [7:0] text_b [6];
    text_a = '{8'h61, 8'h00, 8'h1F, 8'h7F, 8'h80, 8'h9F, 8'hFF, 8'h89, 8'h8A,
               CH_TAB, CH_SPACE, 8'h7E, CH_LF, CH_LF, CH_LF, CH_LF, 8'h62, CH_LF};
    text_b = '{CH_LF, CH_LF, 8'h78, CH_TAB, 8'hFF, CH_LF};
    configure({MODE_ALL, 4'b1111});
    foreach (text_a[i]) send_byte(text_a[i], i == 0);
    settle();
    configure({MODE_NONBLANK, 4'b1000});
    foreach (text_b[i]) send_byte(text_b[i], i == 0);
  endtask

  task automatic random_text(int idle_mode, bit do_hold, bit do_pause);
    case (idle_mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
    for (int i = 0; i < PhaseItems; i++) begin
      if (i == PhaseItems / 2 && do_hold) holds_asked++;
      if (i == PhaseItems / 2 && do_pause) begin
        in_valid <= 1'b0;
        @(negedge clk);
        wait_drained();
      end
      send_byte(random_text_byte(), $urandom_range(39) == 0);
    end
  endtask

  initial begin
    logic [5:0] settings [6];
    settings = '{{MODE_NONE, 4'b0000}, {MODE_ALL, 4'b1111}, {MODE_NONBLANK, 4'b0101},
                 {MODE_THREE, 4'b1111}, {MODE_ALL, 4'b0110}, {MODE_NONBLANK, 4'b1011}};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_text();
    for (int p = 0; p < 8; p++) begin
      settle();
      configure(p < 6 ? settings[p] : 6'($urandom));
      random_text(p % 4, p == 0, p == 1);
    end
    in_valid <= 1'b0;
    @(negedge clk);
    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
